// ===== hdl/arsr_pkg.sv =====
// Shared types and codes for the address range state registry.
`timescale 1ns / 1ps
package arsr_pkg;

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_DECOMMIT = 3'd1,
        OP_COMMIT   = 3'd2,
        OP_DELETE   = 3'd3,
        OP_CLASSIFY = 3'd4
    } t_op;

    localparam logic [1:0] KIND_UNKNOWN   = 2'd0;
    localparam logic [1:0] KIND_COMMITTED = 2'd1;
    localparam logic [1:0] KIND_DECOMMIT  = 2'd2;

    typedef struct packed {
        logic [2:0] pv;
        logic       lost;
        logic       hit;
    } t_split_ctl;

endpackage

// ===== hdl/arsr_ram.sv =====
// Simple dual-port entry memory with registered read data.
`timescale 1ns / 1ps
module arsr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 98
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hdl/arsr_split.sv =====
// Cuts one stored entry against the update range into up to three ordered pieces.
`timescale 1ns / 1ps
module arsr_split import arsr_pkg::*; #(
    parameter int MAX_RANGES = 64,
    parameter int ADDR_BITS  = 48,
    parameter int CW         = $clog2(MAX_RANGES + 1)
) (
    input  logic [2:0]           i_op,
    input  logic [ADDR_BITS-1:0] i_s,
    input  logic [ADDR_BITS:0]   i_e,
    input  logic [ADDR_BITS-1:0] i_rs,
    input  logic [ADDR_BITS:0]   i_re,
    input  logic                 i_rc,
    input  logic [CW-1:0]        i_cnt,
    output t_split_ctl           o_ctl,
    output logic [CW-1:0]        o_cnt,
    output logic [ADDR_BITS-1:0] o_ps [3],
    output logic [ADDR_BITS:0]   o_pe [3],
    output logic                 o_pc [3]
);

    localparam logic [CW:0] MaxW = (CW + 1)'(MAX_RANGES);

    logic ov, lt_s, gt_e, mark, colr, room1, room2;

    assign ov    = (i_re > {1'b0, i_s}) && ({1'b0, i_rs} < i_e);
    assign lt_s  = i_rs < i_s;
    assign gt_e  = i_re > i_e;
    assign mark  = (i_op == OP_DECOMMIT) || (i_op == OP_COMMIT);
    assign colr  = (i_op == OP_COMMIT);
    assign room1 = {1'b0, i_cnt} < MaxW;
    assign room2 = ({1'b0, i_cnt} + (CW + 1)'(2)) <= MaxW;

    always_comb begin
        o_ps[0] = i_rs;
        o_pe[0] = ov ? {1'b0, i_s} : i_re;
        o_pc[0] = i_rc;
        o_ps[1] = lt_s ? i_s : i_rs;
        o_pe[1] = gt_e ? i_e : i_re;
        o_pc[1] = colr;
        o_ps[2] = i_e[ADDR_BITS-1:0];
        o_pe[2] = i_re;
        o_pc[2] = i_rc;
    end

    always_comb begin
        o_ctl.pv   = 3'b000;
        o_ctl.lost = 1'b0;
        o_ctl.hit  = ({1'b0, i_s} < i_re) && (i_s >= i_rs);
        o_cnt      = i_cnt;
        if (!ov) begin
            o_ctl.pv = 3'b001;
        end else if (lt_s && gt_e) begin
            if (mark) begin
                if (room2) begin
                    o_ctl.pv = 3'b111;
                    o_cnt    = i_cnt + CW'(2);
                end else begin
                    o_ctl.lost = 1'b1;
                end
            end else begin
                o_ctl.pv[0] = 1'b1;
                if (room1) begin
                    o_ctl.pv[2] = 1'b1;
                    o_cnt       = i_cnt + CW'(1);
                end else begin
                    o_ctl.lost = 1'b1;
                end
            end
        end else if (lt_s || gt_e) begin
            o_ctl.pv[0] = lt_s;
            o_ctl.pv[2] = gt_e;
            if (mark) begin
                if (room1) begin
                    o_ctl.pv[1] = 1'b1;
                    o_cnt       = i_cnt + CW'(1);
                end else begin
                    o_ctl.lost = 1'b1;
                end
            end
        end else begin
            if (mark) begin
                o_ctl.pv[1] = 1'b1;
            end else begin
                o_cnt = i_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== hdl/address_range_state_registry.sv =====
// Top level: request handshake, table walk sequencer, merge stage and ping-pong entry banks.
// Each request other than a no-op walks the held ranges of the active bank in order
// (sequential bank walk).
// Throughput: one item at a time; a finished result waits in the output register.
// Reset clears the range count, tracking enable and handshake state; bank contents are
// not cleared, entries past the count are never read.
`timescale 1ns / 1ps
module address_range_state_registry import arsr_pkg::*; #(
    parameter int MAX_RANGES = 64,
    parameter int ADDR_BITS  = 48,
    parameter int CW         = $clog2(MAX_RANGES + 1),
    parameter int IW         = ((2 * ADDR_BITS) + 7) / 8 * 8,
    parameter int OW         = ((3 + CW) + 7) / 8 * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [IW-1:0] s_axis_tdata,   // base_address, span_bytes, zero fill
    input  logic [2:0]    s_axis_tuser,   // op
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [OW-1:0] m_axis_tdata    // kind, table_full, entries_used, zero fill
);

    localparam int A  = ADDR_BITS;
    localparam int AW = $clog2(MAX_RANGES);
    localparam int EW = 2 * A + 2;
    localparam logic [CW-1:0] MaxC = CW'(MAX_RANGES);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_EMIT, S_TAIL, S_FLUSH, S_DONE
    } t_state;

    t_state         r_state;
    logic [2:0]     r_op;
    logic [A-1:0]   r_s;
    logic [A:0]     r_e;
    logic           r_en, r_bank, r_ins, r_lost;
    logic [1:0]     r_kind;
    logic [CW-1:0]  r_n, r_cnt, r_idx, r_wptr;
    logic [2:0]     r_pv;
    logic [A-1:0]   r_ps [3];
    logic [A:0]     r_pe [3];
    logic           r_pc [3];
    logic           r_hv, r_hc;
    logic [A-1:0]   r_hs;
    logic [A:0]     r_he;
    logic           r_ov, r_ofull;
    logic [1:0]     r_okind;
    logic [CW-1:0]  r_ocnt;

    logic           accept, noop, in_ins, ins_act, room, join_h, any_pv;
    logic [1:0]     k;
    logic [A-1:0]   in_base, in_span;
    logic [A:0]     in_sum, in_end;
    logic [CW-1:0]  nxt_idx;
    logic           rd_en, wr_en, mg_v, mg_c;
    logic [AW-1:0]  rd_addr;
    logic [A-1:0]   mg_s;
    logic [A:0]     mg_e;
    logic [EW-1:0]  rd_data, rd0, rd1, wr_data;
    t_split_ctl     sp_ctl;
    logic [CW-1:0]  sp_cnt;
    logic [A-1:0]   sp_ps [3];
    logic [A:0]     sp_pe [3];
    logic           sp_pc [3];

    assign in_base = s_axis_tdata[A-1:0];
    assign in_span = s_axis_tdata[2*A-1:A];
    assign in_sum  = {1'b0, in_base} + {1'b0, in_span};
    assign in_end  = in_sum[A] ? {1'b1, {A{1'b0}}} : in_sum;
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign in_ins  = (s_axis_tuser == OP_REGISTER);
    assign noop    = (s_axis_tuser > OP_CLASSIFY) ||
                     ((s_axis_tuser != OP_CLASSIFY) && (!r_en || (in_span == '0)));
    assign nxt_idx = r_idx + CW'(1);
    assign rd_data = r_bank ? rd1 : rd0;
    assign room    = r_cnt < MaxC;
    assign any_pv  = |r_pv;
    assign k       = r_pv[0] ? 2'd0 : (r_pv[1] ? 2'd1 : 2'd2);

    always_comb begin
        ins_act = 1'b0;
        if (r_state == S_EMIT) begin
            ins_act = r_ins && any_pv && ({1'b0, r_ps[k]} >= r_e);
        end else if (r_state == S_TAIL) begin
            ins_act = r_ins;
        end
    end

    always_comb begin
        mg_v = 1'b0;
        mg_s = r_ps[k];
        mg_e = r_pe[k];
        mg_c = r_pc[k];
        if (ins_act) begin
            mg_v = room;
            mg_s = r_s;
            mg_e = r_e;
            mg_c = 1'b1;
        end else if (r_state == S_EMIT) begin
            mg_v = any_pv;
        end
    end

    assign join_h = r_hv && (r_hc == mg_c) && (r_he == {1'b0, mg_s});

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (r_state == S_IDLE) begin
            rd_en = accept && !noop && (r_n != '0);
        end else if (r_state == S_LOAD) begin
            rd_en   = nxt_idx < r_n;
            rd_addr = nxt_idx[AW-1:0];
        end
        wr_en   = (mg_v && r_hv && !join_h) || ((r_state == S_FLUSH) && r_hv);
        wr_data = {r_hc, r_he, r_hs};
    end

    arsr_ram #(.DEPTH(MAX_RANGES), .WIDTH(EW)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (wr_en && r_bank),
        .i_waddr (r_wptr[AW-1:0]),
        .i_wdata (wr_data),
        .i_re    (rd_en && !r_bank),
        .i_raddr (rd_addr),
        .o_rdata (rd0)
    );

    arsr_ram #(.DEPTH(MAX_RANGES), .WIDTH(EW)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (wr_en && !r_bank),
        .i_waddr (r_wptr[AW-1:0]),
        .i_wdata (wr_data),
        .i_re    (rd_en && r_bank),
        .i_raddr (rd_addr),
        .o_rdata (rd1)
    );

    arsr_split #(.MAX_RANGES(MAX_RANGES), .ADDR_BITS(A), .CW(CW)) u_split (
        .i_op  (r_op),
        .i_s   (r_s),
        .i_e   (r_e),
        .i_rs  (rd_data[A-1:0]),
        .i_re  (rd_data[2*A:A]),
        .i_rc  (rd_data[EW-1]),
        .i_cnt (r_cnt),
        .o_ctl (sp_ctl),
        .o_cnt (sp_cnt),
        .o_ps  (sp_ps),
        .o_pe  (sp_pe),
        .o_pc  (sp_pc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_en    <= 1'b0;
            r_n     <= '0;
            r_bank  <= 1'b0;
            r_ov    <= 1'b0;
            r_hv    <= 1'b0;
            r_pv    <= 3'b000;
            r_ins   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_en <= i_cfg_wdata;
            end
            if (r_ov && m_axis_tready && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end
            if (mg_v) begin
                if (join_h) begin
                    r_he <= mg_e;
                end else begin
                    if (r_hv) begin
                        r_wptr <= r_wptr + CW'(1);
                    end
                    r_hv <= 1'b1;
                    r_hs <= mg_s;
                    r_he <= mg_e;
                    r_hc <= mg_c;
                end
            end
            if (ins_act) begin
                r_ins <= 1'b0;
                if (room) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_lost <= 1'b1;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op   <= s_axis_tuser;
                        r_s    <= in_base;
                        r_e    <= in_end;
                        r_lost <= 1'b0;
                        r_kind <= KIND_UNKNOWN;
                        r_hv   <= 1'b0;
                        r_wptr <= '0;
                        r_ins  <= in_ins;
                        r_cnt  <= r_n;
                        r_idx  <= '0;
                        r_pv   <= 3'b000;
                        if (noop) begin
                            r_state <= S_DONE;
                        end else if (r_n == '0) begin
                            r_state <= (s_axis_tuser == OP_CLASSIFY) ? S_DONE : S_TAIL;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_idx <= nxt_idx;
                    if (r_op == OP_CLASSIFY) begin
                        if (sp_ctl.hit) begin
                            r_kind <= rd_data[EW-1] ? KIND_COMMITTED : KIND_DECOMMIT;
                        end
                        if (nxt_idx == r_n) begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_pv    <= sp_ctl.pv;
                        r_ps    <= sp_ps;
                        r_pe    <= sp_pe;
                        r_pc    <= sp_pc;
                        r_cnt   <= sp_cnt;
                        r_lost  <= r_lost | sp_ctl.lost;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!ins_act) begin
                        if (any_pv) begin
                            r_pv[k] <= 1'b0;
                        end else begin
                            r_state <= (r_idx == r_n) ? S_TAIL : S_LOAD;
                        end
                    end
                end
                S_TAIL: begin
                    r_state <= S_FLUSH;
                end
                S_FLUSH: begin
                    r_n     <= r_wptr + CW'(r_hv);
                    r_bank  <= ~r_bank;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_okind <= r_kind;
                        r_ofull <= r_lost;
                        r_ocnt  <= r_n;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(OW - 3 - CW){1'b0}}, r_ocnt, r_ofull, r_okind};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= MaxC)
        else $error("range count above table size");

    a_flush_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> (r_bank != $past(r_bank)))
        else $error("bank did not swap after flush");

    a_wr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_wptr < MaxC))
        else $error("write beyond table size");

endmodule
